>>> design/ipv6_address_to_text_macros.svh
// ----------------------------------------------------------------------------
// ipv6_address_to_text assertion macros
// Clocked assertion shorthands used by the block's checker, ipv6_chk.
// ----------------------------------------------------------------------------
`ifndef IPV6_ADDRESS_TO_TEXT_MACROS_SVH
`define IPV6_ADDRESS_TO_TEXT_MACROS_SVH

// checked only outside reset
`define IPV6_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define IPV6_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> design/ipv6_pkg.sv
// ----------------------------------------------------------------------------
// ipv6_pkg
// Types, constants and helpers shared by the IPv6 address-to-text block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ipv6_pkg;

   localparam int NumGroups = 8;
   localparam int GroupW    = 16;
   localparam int CharW     = 7;

   localparam logic [CharW-1:0] AsciiZero  = 7'h30;
   localparam logic [CharW-1:0] AsciiColon = 7'h3a;
   localparam logic [CharW-1:0] AsciiDot   = 7'h2e;
   localparam logic [CharW-1:0] AsciiHexLo = 7'h57;   // 'a' - 10

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_GROUP,
      ST_HEX,
      ST_DLEAD,
      ST_DEC,
      ST_DOT,
      ST_TAIL
   } state_type;

   typedef enum logic [1:0] {
      CH_COLON,
      CH_DOT,
      CH_HEX,
      CH_DEC
   } char_sel_type;

   typedef struct packed {
      logic         load_ready;
      logic         scan_clear;
      logic         scan_step;
      logic         gi_next;
      logic         nib_load;
      logic         nib_next;
      logic         byte_clear;
      logic         byte_next;
      logic         dig_load;
      logic         dig_next;
      logic         emit;
      logic         emit_last;
      char_sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic load_fire;
      logic load_last;
      logic scan_done;
      logic in_run;
      logic run_start_here;
      logic group_last;
      logic gi_zero;
      logic dotted_here;
      logic nib_zero;
      logic dig_zero;
      logic byte_last;
      logic slot_free;
   } status_type;

   typedef struct packed {
      logic [3:0] h;
      logic [3:0] t;
      logic [3:0] o;
   } dec_type;

   // byte to three decimal digits; tens via x*205 >> 11 on the remainder below 100, where it is exact
   function automatic dec_type to_dec(input logic [7:0] v);
      dec_type     d;
      logic [7:0]  r;
      logic [14:0] p;
      if (v >= 8'd200) begin
         d.h = 4'd2;
         r   = v - 8'd200;
      end else if (v >= 8'd100) begin
         d.h = 4'd1;
         r   = v - 8'd100;
      end else begin
         d.h = 4'd0;
         r   = v;
      end
      p   = 15'(r) * 15'd205;
      d.t = p[14:11];
      d.o = 4'(r - {4'd0, d.t} * 8'd10);
      return d;
   endfunction

   function automatic logic [CharW-1:0] hex_char(input logic [3:0] v);
      return (v < 4'd10) ? AsciiZero + 7'(v) : AsciiHexLo + 7'(v);
   endfunction

endpackage

`default_nettype wire

>>> design/ipv6_ctl.sv
// ----------------------------------------------------------------------------
// ipv6_ctl
// Sequencer: group loading, zero-run scan and character emission steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipv6_ctl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ipv6_pkg::status_type st,
   output ipv6_pkg::cmd_type         cmd
);

   ipv6_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ipv6_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ipv6_pkg::ST_LOAD: begin
            if (st.load_fire && st.load_last) state_in = ipv6_pkg::ST_SCAN;
         end
         ipv6_pkg::ST_SCAN: begin
            if (st.scan_done) state_in = ipv6_pkg::ST_GROUP;
         end
         ipv6_pkg::ST_GROUP: begin
            if (st.slot_free) begin
               if (st.in_run) begin
                  if (st.group_last) state_in = ipv6_pkg::ST_TAIL;
               end else if (st.dotted_here) begin
                  state_in = ipv6_pkg::ST_DLEAD;
               end else begin
                  state_in = ipv6_pkg::ST_HEX;
               end
            end
         end
         ipv6_pkg::ST_HEX: begin
            if (st.slot_free && st.nib_zero) begin
               state_in = st.group_last ? ipv6_pkg::ST_LOAD : ipv6_pkg::ST_GROUP;
            end
         end
         ipv6_pkg::ST_DLEAD: begin
            state_in = ipv6_pkg::ST_DEC;
         end
         ipv6_pkg::ST_DEC: begin
            if (st.slot_free && st.dig_zero) begin
               state_in = st.byte_last ? ipv6_pkg::ST_LOAD : ipv6_pkg::ST_DOT;
            end
         end
         ipv6_pkg::ST_DOT: begin
            if (st.slot_free) state_in = ipv6_pkg::ST_DLEAD;
         end
         ipv6_pkg::ST_TAIL: begin
            if (st.slot_free) state_in = ipv6_pkg::ST_LOAD;
         end
         default: state_in = ipv6_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      cmd     = '0;
      cmd.sel = ipv6_pkg::CH_COLON;
      unique case (state_ff)
         ipv6_pkg::ST_LOAD: begin
            cmd.load_ready = 1'b1;
            cmd.scan_clear = st.load_fire && st.load_last;
         end
         ipv6_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ipv6_pkg::ST_GROUP: begin
            if (st.slot_free) begin
               if (st.in_run) begin
                  cmd.emit    = st.run_start_here;
                  cmd.gi_next = !st.group_last;
               end else begin
                  cmd.emit       = !st.gi_zero;
                  cmd.byte_clear = st.dotted_here;
                  cmd.nib_load   = !st.dotted_here;
               end
            end
         end
         ipv6_pkg::ST_HEX: begin
            cmd.sel = ipv6_pkg::CH_HEX;
            if (st.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = st.nib_zero && st.group_last;
               cmd.gi_next   = st.nib_zero && !st.group_last;
               cmd.nib_next  = !st.nib_zero;
            end
         end
         ipv6_pkg::ST_DLEAD: begin
            cmd.dig_load = 1'b1;
         end
         ipv6_pkg::ST_DEC: begin
            cmd.sel = ipv6_pkg::CH_DEC;
            if (st.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = st.dig_zero && st.byte_last;
               cmd.dig_next  = !st.dig_zero;
            end
         end
         ipv6_pkg::ST_DOT: begin
            cmd.sel = ipv6_pkg::CH_DOT;
            if (st.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.byte_next = 1'b1;
            end
         end
         ipv6_pkg::ST_TAIL: begin
            if (st.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
            end
         end
         default: cmd.sel = ipv6_pkg::CH_COLON;
      endcase
   end

endmodule

`default_nettype wire

>>> design/ipv6_dp.sv
// ----------------------------------------------------------------------------
// ipv6_dp
// Group store, zero-run scan registers, digit counters and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipv6_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [ipv6_pkg::GroupW-1:0]   req_group,
   input  wire logic                          req_valid,
   input  wire ipv6_pkg::cmd_type             cmd,
   output ipv6_pkg::status_type               st,
   output logic      [ipv6_pkg::CharW-1:0]    rsp_char,
   output logic                               rsp_last,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready
);

   localparam logic [3:0] ScanEnd  = 4'(ipv6_pkg::NumGroups);
   localparam logic [2:0] LastIdx  = 3'(ipv6_pkg::NumGroups - 1);

   logic [ipv6_pkg::GroupW-1:0] grp_ff [ipv6_pkg::NumGroups];
   logic [ipv6_pkg::NumGroups-1:0] zflag_ff;

   logic [2:0] cnt_ff, cnt_in;
   logic [3:0] scan_ff, scan_in;
   logic [2:0] cur_start_ff, cur_start_in;
   logic [3:0] cur_len_ff, cur_len_in;
   logic [2:0] best_start_ff, best_start_in;
   logic [3:0] best_len_ff, best_len_in;
   logic [2:0] gi_ff, gi_in;
   logic [1:0] nib_ff, nib_in;
   logic [1:0] byte_ff, byte_in;
   logic [1:0] dig_ff, dig_in;
   logic [ipv6_pkg::CharW-1:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       valid_ff, valid_in;

   logic                        load;
   logic                        scan_zero;
   logic                        has_run;
   logic [3:0]                  run_end;
   logic                        dotted;
   logic [ipv6_pkg::GroupW-1:0] grp_sel;
   logic [1:0]                  lead_nib;
   logic [3:0]                  nib_val;
   logic [7:0]                  byte_val;
   ipv6_pkg::dec_type           dec;
   logic [1:0]                  lead_dig;
   logic [3:0]                  dig_val;

   assign load = req_valid && cmd.load_ready;

   // group store, write side
   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff[cnt_ff]   <= req_group;
         zflag_ff[cnt_ff] <= (req_group == '0);
      end
   end

   assign cnt_in = load ? cnt_ff + 3'd1 : cnt_ff;

   // zero-run scan, one group per step plus a closing step
   assign scan_zero = (scan_ff != ScanEnd) && zflag_ff[scan_ff[2:0]];

   always_comb begin
      scan_in       = scan_ff;
      cur_start_in  = cur_start_ff;
      cur_len_in    = cur_len_ff;
      best_start_in = best_start_ff;
      best_len_in   = best_len_ff;
      if (cmd.scan_clear) begin
         scan_in       = '0;
         cur_len_in    = '0;
         best_start_in = '0;
         best_len_in   = '0;
      end else if (cmd.scan_step) begin
         scan_in = scan_ff + 4'd1;
         if (scan_zero) begin
            if (cur_len_ff == '0) begin
               cur_start_in = scan_ff[2:0];
               cur_len_in   = 4'd1;
            end else begin
               cur_len_in = cur_len_ff + 4'd1;
            end
         end else if (cur_len_ff != '0) begin
            if (cur_len_ff > best_len_ff) begin
               best_start_in = cur_start_ff;
               best_len_in   = cur_len_ff;
            end
            cur_len_in = '0;
         end
      end
   end

   assign has_run = best_len_ff >= 4'd2;
   assign run_end = {1'b0, best_start_ff} + best_len_ff;
   assign dotted  = has_run && (best_start_ff == '0) &&
                    ((best_len_ff == 4'd6) ||
                     ((best_len_ff == 4'd5) && (grp_ff[5] == 16'hffff)));

   // hex digits
   assign grp_sel = grp_ff[gi_ff];

   always_comb begin
      priority if (grp_sel[15:12] != '0) lead_nib = 2'd3;
      else if     (grp_sel[11:8]  != '0) lead_nib = 2'd2;
      else if     (grp_sel[7:4]   != '0) lead_nib = 2'd1;
      else                               lead_nib = 2'd0;
   end

   assign nib_val = grp_sel[{nib_ff, 2'b00} +: 4];

   // dotted-decimal tail: bytes of the last two groups
   always_comb begin
      unique case (byte_ff)
         2'd0:    byte_val = grp_ff[6][15:8];
         2'd1:    byte_val = grp_ff[6][7:0];
         2'd2:    byte_val = grp_ff[7][15:8];
         default: byte_val = grp_ff[7][7:0];
      endcase
   end

   assign dec = ipv6_pkg::to_dec(byte_val);

   always_comb begin
      priority if (dec.h != '0) lead_dig = 2'd2;
      else if     (dec.t != '0) lead_dig = 2'd1;
      else                      lead_dig = 2'd0;
   end

   always_comb begin
      unique case (dig_ff)
         2'd2:    dig_val = dec.h;
         2'd1:    dig_val = dec.t;
         default: dig_val = dec.o;
      endcase
   end

   always_comb begin
      gi_in   = gi_ff;
      nib_in  = nib_ff;
      byte_in = byte_ff;
      dig_in  = dig_ff;
      if (cmd.scan_clear)    gi_in   = '0;
      else if (cmd.gi_next)  gi_in   = gi_ff + 3'd1;
      if (cmd.nib_load)      nib_in  = lead_nib;
      else if (cmd.nib_next) nib_in  = nib_ff - 2'd1;
      if (cmd.byte_clear)    byte_in = '0;
      else if (cmd.byte_next) byte_in = byte_ff + 2'd1;
      if (cmd.dig_load)      dig_in  = lead_dig;
      else if (cmd.dig_next) dig_in  = dig_ff - 2'd1;
   end

   // output register
   always_comb begin
      char_in  = char_ff;
      last_in  = last_ff;
      valid_in = valid_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         last_in  = cmd.emit_last;
         unique case (cmd.sel)
            ipv6_pkg::CH_COLON: char_in = ipv6_pkg::AsciiColon;
            ipv6_pkg::CH_DOT:   char_in = ipv6_pkg::AsciiDot;
            ipv6_pkg::CH_HEX:   char_in = ipv6_pkg::hex_char(nib_val);
            ipv6_pkg::CH_DEC:   char_in = ipv6_pkg::AsciiZero + 7'(dig_val);
            default:            char_in = ipv6_pkg::AsciiColon;
         endcase
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      cur_start_ff  <= cur_start_in;
      cur_len_ff    <= cur_len_in;
      best_start_ff <= best_start_in;
      best_len_ff   <= best_len_in;
      gi_ff         <= gi_in;
      nib_ff        <= nib_in;
      byte_ff       <= byte_in;
      dig_ff        <= dig_in;
      char_ff       <= char_in;
      last_ff       <= last_in;
   end

   always_comb begin
      st.load_fire      = load;
      st.load_last      = (cnt_ff == LastIdx);
      st.scan_done      = (scan_ff == ScanEnd);
      st.in_run         = has_run && (gi_ff >= best_start_ff) &&
                          ({1'b0, gi_ff} < run_end);
      st.run_start_here = (gi_ff == best_start_ff);
      st.group_last     = (gi_ff == LastIdx);
      st.gi_zero        = (gi_ff == '0);
      st.dotted_here    = dotted && (gi_ff == 3'd6);
      st.nib_zero       = (nib_ff == '0);
      st.dig_zero       = (dig_ff == '0);
      st.byte_last      = (byte_ff == 2'd3);
      st.slot_free      = !valid_ff || rsp_ready;
   end

   assign rsp_char  = char_ff;
   assign rsp_last  = last_ff;
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

>>> design/ipv6_address_to_text.sv
// ----------------------------------------------------------------------------
// ipv6_address_to_text
// Loading: one group per cycle is taken; after the eighth group the zero-run
// scan runs over the stored groups before the first character is emitted.
// Throughput: one character per cycle while rsp_tready holds, plus one idle
// step for a first group outside the zero run, per skipped zero group and per
// decimal byte. req_tready is low from the eighth group to the last character.
// Reset (synchronous) empties the group count and the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipv6_address_to_text (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,    // [15:0] group
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,    // [6:0] text_char, [7] zero
   output logic             rsp_tlast     // last_char
);

   ipv6_pkg::cmd_type              cmd;
   ipv6_pkg::status_type           st;
   logic [ipv6_pkg::CharW-1:0]     rsp_char;

   ipv6_ctl u_ctl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   ipv6_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_group (req_tdata),
      .req_valid (req_tvalid),
      .cmd       (cmd),
      .st        (st),
      .rsp_char  (rsp_char),
      .rsp_last  (rsp_tlast),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready)
   );

   assign req_tready = cmd.load_ready;
   assign rsp_tdata  = {1'b0, rsp_char};

endmodule

`default_nettype wire

>>> design/ipv6_chk.sv
// ----------------------------------------------------------------------------
// ipv6_chk
// Port-level checks for ipv6_address_to_text, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ipv6_address_to_text_macros.svh"

module ipv6_chk (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast
);

   logic [8:0] rsp_word;
   logic       stalled;
   logic       mid_text;
   logic       last_done;
   logic       char_ok;

   assign rsp_word  = {rsp_tlast, rsp_tdata};
   assign stalled   = rsp_tvalid && !rsp_tready;
   assign mid_text  = rsp_tvalid && !rsp_tlast;
   assign last_done = rsp_tvalid && rsp_tready && rsp_tlast;
   assign char_ok   = !rsp_tdata[7] &&
                      ((rsp_tdata[6:0] >= ipv6_pkg::AsciiZero &&
                        rsp_tdata[6:0] <= ipv6_pkg::AsciiColon) ||
                       (rsp_tdata[6:0] >= ipv6_pkg::AsciiHexLo + 7'd10 &&
                        rsp_tdata[6:0] <= ipv6_pkg::AsciiHexLo + 7'd15) ||
                       (rsp_tdata[6:0] == ipv6_pkg::AsciiDot));

   `IPV6_ASSERT_RST(a_reset_idle, reset |=> (!rsp_tvalid && req_tready), "not idle after reset")

   `IPV6_ASSERT(a_rsp_hold, stalled |=> (rsp_tvalid && $stable(rsp_word)), "stall changed data")

   `IPV6_ASSERT(a_no_load_mid_text, mid_text |-> !req_tready, "group taken while text pending")

   `IPV6_ASSERT(a_char_legal, rsp_tvalid |-> char_ok, "illegal character")

   `IPV6_ASSERT(a_gap_after_last, last_done |=> !rsp_tvalid, "character right after last")

endmodule

bind ipv6_address_to_text ipv6_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
